/* src/irppm_pkg.sv */
package irppm_pkg;

    localparam int unsigned DUR_W    = 8;
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned CQ_DEPTH = 2;
    localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_PULSE_LEVELS     = 3'd0;
    localparam logic [2:0] REG_MARK_LEN_FOUR    = 3'd1;
    localparam logic [2:0] REG_MARK_LEN_SIXTEEN = 3'd2;
    localparam logic [2:0] REG_GAP_SYM_ZERO     = 3'd3;
    localparam logic [2:0] REG_GAP_SYM_ONE      = 3'd4;
    localparam logic [2:0] REG_GAP_SYM_TWO      = 3'd5;
    localparam logic [2:0] REG_GAP_SYM_THREE    = 3'd6;

    // last result index of each phase
    localparam logic [3:0] HDR_LAST    = 4'd15;
    localparam logic [3:0] BODY16_LAST = 4'd3;
    localparam logic [3:0] BODY4_LAST  = 4'd7;

    localparam logic [3:0][7:0] HEADER_BYTES = {8'h40, 8'h00, 8'h00, 8'h00};

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [DUR_W-1:0] span_us;
        logic             is_mark;
        logic             closing_mark;
        logic             run_last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       sixteen;
        logic       header;
    } t_cmd;

    typedef struct packed {
        logic                  pulse_levels;
        logic [DUR_W-1:0]      mark_len_four;
        logic [DUR_W-1:0]      mark_len_sixteen;
        logic [3:0][DUR_W-1:0] gap_sym;
    } t_cfg;

    typedef enum logic [2:0] {
        PH_HDR   = 3'b001,
        PH_BODY  = 3'b010,
        PH_CLOSE = 3'b100
    } t_phase;

    function automatic logic [DUR_W-1:0] sixteen_gap(input logic [3:0] nib);
        logic [DUR_W-1:0] g;
        unique case (nib)
            4'd0:  g = 8'd27;
            4'd1:  g = 8'd51;
            4'd2:  g = 8'd35;
            4'd3:  g = 8'd43;
            4'd4:  g = 8'd147;
            4'd5:  g = 8'd123;
            4'd6:  g = 8'd139;
            4'd7:  g = 8'd131;
            4'd8:  g = 8'd83;
            4'd9:  g = 8'd59;
            4'd10: g = 8'd75;
            4'd11: g = 8'd67;
            4'd12: g = 8'd91;
            4'd13: g = 8'd115;
            4'd14: g = 8'd99;
            default: g = 8'd107;
        endcase
        return g;
    endfunction

    // nibble of header symbol s: byte s[2:1], high nibble when s[0]
    function automatic logic [3:0] hdr_nibble(input logic [2:0] s);
        logic [7:0] b;
        b = HEADER_BYTES[s[2:1]];
        return s[0] ? b[7:4] : b[3:0];
    endfunction

endpackage

/* src/irppm_front.sv */
module irppm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  irppm_pkg::t_in_item i_item,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_pulse_levels,
    input  logic              i_q_full,
    output logic              o_q_push,
    output irppm_pkg::t_cmd   o_cmd
);
    import irppm_pkg::*;

    logic r_inside_frame;
    logic n_inside_frame;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_cmd.frame_byte = i_item.frame_byte;
        o_cmd.last_byte  = i_item.last_byte;
        o_cmd.sixteen    = i_pulse_levels;
        o_cmd.header     = i_pulse_levels && !r_inside_frame;
        n_inside_frame   = r_inside_frame;
        if (o_q_push) begin
            n_inside_frame = !i_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_frame <= 1'b0;
        end else begin
            r_inside_frame <= n_inside_frame;
        end
    end

endmodule

/* src/irppm_cmdq.sv */
module irppm_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  irppm_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output irppm_pkg::t_cmd o_cmd
);
    import irppm_pkg::*;

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr_ptr;
    logic [CQ_AW-1:0] r_rd_ptr;
    logic [CQ_AW:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (CQ_AW+1)'(CQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CQ_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CQ_AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (CQ_AW+1)'(1);
                2'b01:   r_count <= r_count - (CQ_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/irppm_back.sv */
module irppm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  irppm_pkg::t_cfg      i_cfg,
    input  logic                 i_cmd_valid,
    input  irppm_pkg::t_cmd      i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output irppm_pkg::t_out_item o_result
);
    import irppm_pkg::*;

    t_phase    r_phase;
    t_phase    n_phase;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    t_out_item r_out;
    t_out_item res;
    logic      r_out_valid;
    logic      advance;
    logic      finish;
    t_phase    eff_phase;
    logic [3:0] nib;
    logic [1:0] sym;
    logic [3:0] body_last;

    assign advance   = i_cmd_valid && (!r_out_valid || i_pop);
    assign o_cmd_pop = advance && finish;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;
    assign body_last = i_cmd.sixteen ? BODY16_LAST : BODY4_LAST;

    always_comb begin
        // skip the header phase for commands that carry none
        eff_phase = r_phase;
        if (r_phase == PH_HDR && !i_cmd.header) begin
            eff_phase = PH_BODY;
        end
        nib              = '0;
        sym              = i_cmd.frame_byte[{r_cnt[2:1], 1'b0} +: 2];
        res.span_us      = '0;
        res.is_mark      = 1'b0;
        res.closing_mark = 1'b0;
        res.run_last     = 1'b0;
        finish           = 1'b0;
        n_phase          = r_phase;
        n_cnt            = r_cnt + 4'd1;
        unique case (eff_phase)
            PH_HDR: begin
                nib         = hdr_nibble(r_cnt[3:1]);
                res.is_mark = !r_cnt[0];
                res.span_us = r_cnt[0] ? sixteen_gap(nib) : i_cfg.mark_len_sixteen;
                if (r_cnt == HDR_LAST) begin
                    n_phase = PH_BODY;
                    n_cnt   = '0;
                end
            end
            PH_BODY: begin
                nib         = r_cnt[1] ? i_cmd.frame_byte[7:4] : i_cmd.frame_byte[3:0];
                res.is_mark = !r_cnt[0];
                if (i_cmd.sixteen) begin
                    res.span_us = r_cnt[0] ? sixteen_gap(nib) : i_cfg.mark_len_sixteen;
                end else begin
                    res.span_us = r_cnt[0] ? i_cfg.gap_sym[sym] : i_cfg.mark_len_four;
                end
                n_phase = PH_BODY;
                if (r_cnt == body_last) begin
                    n_cnt = '0;
                    if (i_cmd.last_byte) begin
                        n_phase = PH_CLOSE;
                    end else begin
                        finish       = 1'b1;
                        res.run_last = 1'b1;
                        n_phase      = PH_HDR;
                    end
                end
            end
            PH_CLOSE: begin
                res.span_us      = i_cmd.sixteen ? i_cfg.mark_len_sixteen
                                                 : i_cfg.mark_len_four;
                res.is_mark      = 1'b1;
                res.closing_mark = 1'b1;
                res.run_last     = 1'b1;
                finish           = 1'b1;
                n_phase          = PH_HDR;
                n_cnt            = '0;
            end
            default: begin
                n_phase = PH_HDR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_close_is_final_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.closing_mark) |-> (r_out.is_mark && r_out.run_last))
        else $error("closing mark must be a mark ending its transaction");

    a_open_byte_ends_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.run_last && !r_out.closing_mark) |-> !r_out.is_mark)
        else $error("byte without closing mark must end on a gap");

    a_close_needs_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSE) |-> (i_cmd_valid && i_cmd.last_byte))
        else $error("closing phase without a last byte at queue head");

    a_pop_on_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_out_valid && r_out.run_last))
        else $error("command retired without a run_last result");
`endif

endmodule

/* src/ir_ppm_symbol_encoder.sv */
// IR pulse-position symbol encoder. Push frame bytes (last_byte marks the end of
// a frame); pop alternating carrier marks and gaps in microseconds, one result
// per cycle while a command is queued and the result register is free or popped.
// A 4-level byte gives 8 results, a 16-level byte 4, the first byte of a 16-level
// frame 16 more for the 00 00 00 40 header, and the last byte one closing mark.
// A two-entry command queue lets pushes proceed while earlier bytes are still
// expanding. Registers sit on an APB port at byte offsets 4*i; reads return only
// the stored bits (bit 0 or bits 7:0), zero-extended.
module ir_ppm_symbol_encoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irppm_pkg::PADDR_W-1:0] paddr,
    input  logic [irppm_pkg::PDATA_W-1:0] pwdata,
    output logic [irppm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  irppm_pkg::t_in_item          i_item,
    output logic                         empty,
    input  logic                         pop,
    output irppm_pkg::t_out_item         o_result
);
    import irppm_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    t_cmd       front_cmd;
    t_cmd       head_cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_levels     <= 1'b1;
            r_cfg.mark_len_four    <= 8'd40;
            r_cfg.mark_len_sixteen <= 8'd21;
            r_cfg.gap_sym[0]       <= 8'd61;
            r_cfg.gap_sym[1]       <= 8'd244;
            r_cfg.gap_sym[2]       <= 8'd122;
            r_cfg.gap_sym[3]       <= 8'd183;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_PULSE_LEVELS:     r_cfg.pulse_levels     <= pwdata[0];
                REG_MARK_LEN_FOUR:    r_cfg.mark_len_four    <= pwdata[7:0];
                REG_MARK_LEN_SIXTEEN: r_cfg.mark_len_sixteen <= pwdata[7:0];
                REG_GAP_SYM_ZERO:     r_cfg.gap_sym[0]       <= pwdata[7:0];
                REG_GAP_SYM_ONE:      r_cfg.gap_sym[1]       <= pwdata[7:0];
                REG_GAP_SYM_TWO:      r_cfg.gap_sym[2]       <= pwdata[7:0];
                REG_GAP_SYM_THREE:    r_cfg.gap_sym[3]       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PULSE_LEVELS:     prdata = {31'd0, r_cfg.pulse_levels};
            REG_MARK_LEN_FOUR:    prdata = {24'd0, r_cfg.mark_len_four};
            REG_MARK_LEN_SIXTEEN: prdata = {24'd0, r_cfg.mark_len_sixteen};
            REG_GAP_SYM_ZERO:     prdata = {24'd0, r_cfg.gap_sym[0]};
            REG_GAP_SYM_ONE:      prdata = {24'd0, r_cfg.gap_sym[1]};
            REG_GAP_SYM_TWO:      prdata = {24'd0, r_cfg.gap_sym[2]};
            REG_GAP_SYM_THREE:    prdata = {24'd0, r_cfg.gap_sym[3]};
            default:              prdata = '0;
        endcase
    end

    irppm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_push         (push),
        .o_full         (full),
        .i_pulse_levels (r_cfg.pulse_levels),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_cmd          (front_cmd)
    );

    irppm_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    irppm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

/* tb/sv/ir_ppm_symbol_encoder_checker.sv */
`timescale 1ns / 100ps

module ir_ppm_symbol_encoder_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [irppm_pkg::PADDR_W-1:0] i_paddr,
    input  logic [irppm_pkg::PDATA_W-1:0] i_pwdata,
    input  logic                          i_pready,
    input  logic                          i_push,
    input  logic                          i_full,
    input  irppm_pkg::t_in_item           i_item,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  irppm_pkg::t_out_item          i_result,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_bytes_seen,
    output int                            o_pulses_checked,
    output int                            o_headers_seen,
    output int                            o_closings_seen
);
    import irppm_pkg::*;

    // gap per 16-level nibble, index 0 in the low byte
    localparam logic [15:0][7:0] NIBBLE_GAP = {
        8'd107, 8'd99,  8'd115, 8'd91,  8'd67,  8'd75,  8'd59,  8'd83,
        8'd131, 8'd139, 8'd123, 8'd147, 8'd43,  8'd35,  8'd51,  8'd27
    };
    // frame preamble bytes 00 00 00 40, first byte in the low byte
    localparam logic [3:0][7:0] PREAMBLE = 32'h4000_0000;

    logic            levels16;
    logic [7:0]      mark4;
    logic [7:0]      mark16;
    logic [3:0][7:0] gap4;
    logic            frame_open;

    t_out_item pulse_plan[$];
    t_out_item awaited[$];

    int mismatches;
    int bytes_seen;
    int pulses_checked;
    int headers_seen;
    int closings_seen;

    initial begin
        mismatches     = 0;
        bytes_seen     = 0;
        pulses_checked = 0;
        headers_seen   = 0;
        closings_seen  = 0;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] pulse mismatch: %s", $time, what);
    endtask

    function automatic void plan_pulse(input logic [7:0] dur, input logic mark,
                                       input logic closing);
        t_out_item r;
        r.span_us      = dur;
        r.is_mark      = mark;
        r.closing_mark = closing;
        r.run_last     = 1'b0;
        pulse_plan.push_back(r);
    endfunction

    function automatic void plan_byte(input logic [7:0] b, input logic sixteen);
        if (sixteen) begin
            for (int k = 0; k < 2; k++) begin
                plan_pulse(mark16, 1'b1, 1'b0);
                plan_pulse(NIBBLE_GAP[b[4*k +: 4]], 1'b0, 1'b0);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                plan_pulse(mark4, 1'b1, 1'b0);
                plan_pulse(gap4[b[2*k +: 2]], 1'b0, 1'b0);
            end
        end
    endfunction

    function automatic void predict_pulses(input t_in_item it);
        logic      sixteen;
        t_out_item tail;
        sixteen = levels16;
        pulse_plan.delete();
        if (sixteen && !frame_open) begin
            for (int h = 0; h < 4; h++) begin
                plan_byte(PREAMBLE[h], 1'b1);
            end
            headers_seen++;
        end
        plan_byte(it.frame_byte, sixteen);
        if (it.last_byte) begin
            plan_pulse(sixteen ? mark16 : mark4, 1'b1, 1'b1);
            frame_open = 1'b0;
            closings_seen++;
        end else begin
            frame_open = 1'b1;
        end
        tail = pulse_plan.pop_back();
        tail.run_last = 1'b1;
        pulse_plan.push_back(tail);
        foreach (pulse_plan[i]) begin
            awaited.push_back(pulse_plan[i]);
        end
        bytes_seen++;
    endfunction

    function automatic void apply_write(input logic [2:0] idx, input logic [7:0] v);
        case (idx)
            REG_PULSE_LEVELS:     levels16 = v[0];
            REG_MARK_LEN_FOUR:    mark4    = v;
            REG_MARK_LEN_SIXTEEN: mark16   = v;
            REG_GAP_SYM_ZERO:     gap4[0]  = v;
            REG_GAP_SYM_ONE:      gap4[1]  = v;
            REG_GAP_SYM_TWO:      gap4[2]  = v;
            REG_GAP_SYM_THREE:    gap4[3]  = v;
            default: ;
        endcase
    endfunction

    task automatic check_pulse(input t_out_item got);
        t_out_item want;
        if (awaited.size() == 0) begin
            flag_mismatch($sformatf("result with nothing awaited: dur=%0d mark=%0b",
                                    got.span_us, got.is_mark));
            return;
        end
        want = awaited.pop_front();
        if (got.span_us !== want.span_us) begin
            flag_mismatch($sformatf("span_us got %0d want %0d",
                                    got.span_us, want.span_us));
        end
        if (got.is_mark !== want.is_mark) begin
            flag_mismatch($sformatf("is_mark got %b want %b", got.is_mark, want.is_mark));
        end
        if (got.closing_mark !== want.closing_mark) begin
            flag_mismatch($sformatf("closing_mark got %b want %b",
                                    got.closing_mark, want.closing_mark));
        end
        if (got.run_last !== want.run_last) begin
            flag_mismatch($sformatf("run_last got %b want %b",
                                    got.run_last, want.run_last));
        end
        pulses_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            levels16   = 1'b1;
            mark4      = 8'd40;
            mark16     = 8'd21;
            gap4       = {8'd183, 8'd122, 8'd244, 8'd61};
            frame_open = 1'b0;
            awaited.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                apply_write(i_paddr[4:2], i_pwdata[7:0]);
            end
            // check before predicting: a result popped now comes from older bytes
            if (i_pop && !i_empty) begin
                check_pulse(i_result);
            end
            if (i_push && !i_full) begin
                predict_pulses(i_item);
            end
        end
        o_mismatches     <= mismatches;
        o_pending        <= awaited.size();
        o_bytes_seen     <= bytes_seen;
        o_pulses_checked <= pulses_checked;
        o_headers_seen   <= headers_seen;
        o_closings_seen  <= closings_seen;
    end

endmodule

/* tb/sv/ir_ppm_symbol_encoder_tb.sv */
`timescale 1ns / 100ps

module ir_ppm_symbol_encoder_tb;
    import irppm_pkg::*;

    localparam logic [2:0] REG_UNMAPPED  = 3'd7;
    localparam int         RANDOM_PHASES = 8;
    localparam int         PHASE_BYTES   = 44;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               push    = 1'b0;
    logic               full;
    t_in_item           i_item  = '0;
    logic               empty;
    logic               pop     = 1'b0;
    t_out_item          o_result;

    int mismatches;
    int pending;
    int bytes_seen;
    int pulses_checked;
    int headers_seen;
    int closings_seen;
    int settings_used = 0;
    bit calm_push     = 1'b0;
    bit calm_pop      = 1'b0;

    ir_ppm_symbol_encoder u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    ir_ppm_symbol_encoder_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .i_pready         (pready),
        .i_push           (push),
        .i_full           (full),
        .i_item           (i_item),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_result         (o_result),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_bytes_seen     (bytes_seen),
        .o_pulses_checked (pulses_checked),
        .o_headers_seen   (headers_seen),
        .o_closings_seen  (closings_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: stall a random number of cycles before each transaction
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = calm_pop ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = calm_push ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_item.frame_byte <= b;
        i_item.last_byte  <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // drop push and hold until every predicted result has been popped
    task automatic drain;
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [7:0] value);
        logic [PDATA_W-1:0] word;
        word       = $urandom;
        word[7:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return to idle between transactions
        @(posedge i_clk);
    endtask

    task automatic set_levels(input logic sixteen);
        logic [6:0] junk;
        junk = 7'($urandom);
        apb_write(REG_PULSE_LEVELS, {junk, sixteen});
    endtask

    task automatic program_registers(input logic sixteen, input logic [7:0] m4,
                                     input logic [7:0] m16, input logic [7:0] g0,
                                     input logic [7:0] g1, input logic [7:0] g2,
                                     input logic [7:0] g3);
        set_levels(sixteen);
        apb_write(REG_MARK_LEN_FOUR, m4);
        apb_write(REG_MARK_LEN_SIXTEEN, m16);
        apb_write(REG_GAP_SYM_ZERO, g0);
        apb_write(REG_GAP_SYM_ONE, g1);
        apb_write(REG_GAP_SYM_TWO, g2);
        apb_write(REG_GAP_SYM_THREE, g3);
        settings_used++;
    endtask

    function automatic logic [7:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int         frame_left;
        logic       last;
        logic [7:0] b;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: 16-level frames, header on each new frame
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();

        // 4-level with extreme marks and gaps; the unmapped index must be ignored
        program_registers(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE);
        apb_write(REG_UNMAPPED, pick_duration());
        send_byte(8'hE4, 1'b0);
        send_byte(8'h1B, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // switch modes in the middle of a frame: no header on the switch
        send_byte(8'h3C, 1'b0);
        drain();
        set_levels(1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h96, 1'b1);
        drain();
        set_levels(1'b0);
        send_byte(8'h81, 1'b0);
        drain();
        set_levels(1'b1);
        send_byte(8'h42, 1'b1);
        drain();

        program_registers(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        program_registers(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_byte(8'h12, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'hBD, 1'b1);
        drain();

        frame_left = 0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm_push = ($urandom_range(0, 3) == 0);
            calm_pop  = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                program_registers(1'b1, 8'd40, 8'd21, 8'd61, 8'd244, 8'd122, 8'd183);
            end else begin
                if ($urandom_range(0, 1)) set_levels(1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1)) apb_write(REG_MARK_LEN_FOUR, pick_duration());
                if ($urandom_range(0, 1)) apb_write(REG_MARK_LEN_SIXTEEN, pick_duration());
                if ($urandom_range(0, 1)) apb_write(REG_GAP_SYM_ZERO, pick_duration());
                if ($urandom_range(0, 1)) apb_write(REG_GAP_SYM_ONE, pick_duration());
                if ($urandom_range(0, 1)) apb_write(REG_GAP_SYM_TWO, pick_duration());
                if ($urandom_range(0, 1)) apb_write(REG_GAP_SYM_THREE, pick_duration());
                if ($urandom_range(0, 3) == 0) apb_write(REG_UNMAPPED, pick_duration());
                settings_used++;
            end
            for (int n = 0; n < PHASE_BYTES; n++) begin
                if (frame_left == 0) begin
                    frame_left = $urandom_range(1, 6);
                end
                last = (frame_left == 1);
                frame_left--;
                // noise: break the frame structure now and then
                if ($urandom_range(0, 6) == 0) begin
                    last = 1'($urandom_range(0, 1));
                end
                b = pick_byte();
                send_byte(b, last);
            end
            drain();
        end

        // hold a while longer so a stray result would still show up
        repeat (40) @(posedge i_clk);
        $display("covered %0d bytes over %0d register settings, %0d headers, %0d frames closed",
                 bytes_seen, settings_used, headers_seen, closings_seen);
        $display("checked %0d mark/gap results, %0d still awaited", pulses_checked, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
